// ----- rtl/bsc_pkg.sv -----
package bsc_pkg;

  localparam int unsigned MaxNetworksDef   = 16;
  localparam int unsigned MaxFrameBytesDef = 4095;
  localparam int unsigned SsidFieldBytes   = 33;
  localparam int unsigned SsidSlot         = 32;
  localparam int unsigned BodyStart        = 36;

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    STS_IGNORED  = 3'd0,
    STS_UPDATED  = 3'd1,
    STS_INSERTED = 3'd2,
    STS_FULL     = 3'd3,
    STS_READ     = 3'd4,
    STS_EMPTY    = 3'd5
  } status_e;

  localparam logic [1:0] SEC_OPEN = 2'd0;
  localparam logic [1:0] SEC_WPA  = 2'd1;
  localparam logic [1:0] SEC_WPA2 = 2'd2;

  localparam logic [7:0] EID_SSID    = 8'd0;
  localparam logic [7:0] EID_CHANNEL = 8'd3;
  localparam logic [7:0] EID_RSN     = 8'd48;
  localparam logic [7:0] EID_VENDOR  = 8'd221;

  localparam logic [7:0] OUI_0    = 8'h00;
  localparam logic [7:0] OUI_1    = 8'h50;
  localparam logic [7:0] OUI_2    = 8'hF2;
  localparam logic [7:0] OUI_TYPE = 8'h01;

  localparam logic [3:0] SUB_BEACON = 4'd8;
  localparam logic [3:0] SUB_PRESP  = 4'd5;

  typedef struct packed {
    logic [47:0] bssid;
    logic [7:0]  channel;
    logic [1:0]  security;
    logic [5:0]  name_len;
  } bsc_entry_t;

  typedef struct packed {
    logic valid;
    logic write_entry;
    logic write_chan;
    logic pick;
  } bsc_cell_ctrl_t;

  typedef struct packed {
    logic        pos_ok;
    logic [7:0]  fc;
    logic [47:0] bssid;
    logic [5:0]  name_len;
    logic [7:0]  channel;
    logic [1:0]  security;
  } bsc_frame_t;

endpackage

// ----- rtl/bsc_ram.sv -----
module bsc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/bsc_cell.sv -----
module bsc_cell #(
  parameter int unsigned IDX_W = 4,
  parameter int unsigned IDX   = 0
) (
  input  logic                   clk_i,
  input  bsc_pkg::bsc_cell_ctrl_t ctrl_i,
  input  bsc_pkg::bsc_entry_t    wr_i,
  input  logic [47:0]            key_i,
  input  logic                   hit_i,
  input  bsc_pkg::bsc_entry_t    entry_i,
  input  logic [IDX_W-1:0]       idx_i,
  output logic                   hit_o,
  output logic                   first_o,
  output bsc_pkg::bsc_entry_t    entry_o,
  output logic [IDX_W-1:0]       idx_o
);
  import bsc_pkg::*;

  bsc_entry_t ent_q;
  logic       match;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.write_entry) begin
      ent_q <= wr_i;
    end else if (ctrl_i.write_chan) begin
      ent_q.channel <= wr_i.channel;
    end
  end

  // earliest matching cell wins, as in a linear search
  assign match   = ctrl_i.valid && (ent_q.bssid == key_i);
  assign first_o = match && !hit_i;
  assign hit_o   = hit_i || match;
  assign entry_o = ctrl_i.pick ? (entry_i | ent_q) : entry_i;
  assign idx_o   = ctrl_i.pick ? (idx_i | IDX_W'(IDX)) : idx_i;

endmodule

// ----- rtl/bsc_parser.sv -----
module bsc_parser #(
  parameter int unsigned MAX_FRAME_BYTES = bsc_pkg::MaxFrameBytesDef,
  localparam int unsigned PW = $clog2(MAX_FRAME_BYTES + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 byte_vld_i,
  input  logic [7:0]           byte_i,
  input  logic                 restart_i,
  input  logic [4:0]           rd_idx_i,
  output bsc_pkg::bsc_frame_t  frame_o,
  output logic [7:0]           ssid_byte_o
);
  import bsc_pkg::*;

  typedef enum logic [2:0] {
    PH_ID   = 3'b001,
    PH_LEN  = 3'b010,
    PH_BODY = 3'b100
  } phase_e;

  logic [PW-1:0] pos_q, pos_d;
  logic [7:0]    fc_q, fc_d;
  logic [47:0]   bssid_q, bssid_d;
  phase_e        phase_q, phase_d;
  logic [7:0]    id_q, id_d, len_q, len_d, off_q, off_d;
  logic [5:0]    flen_q, flen_d;
  logic [7:0]    fchan_q, fchan_d, pchan_q, pchan_d;
  logic [1:0]    sec_q, sec_d;
  logic          oui_q, oui_d;
  logic [7:0]    pend_q [SsidSlot];
  logic [7:0]    pend_d [SsidSlot];
  logic [7:0]    found_q [SsidSlot];
  logic [7:0]    found_d [SsidSlot];
  logic          done;
  logic [7:0]    dlen;
  logic [7:0]    off_nx;

  always_comb begin
    pos_d   = pos_q;
    fc_d    = fc_q;
    bssid_d = bssid_q;
    phase_d = phase_q;
    id_d    = id_q;
    len_d   = len_q;
    off_d   = off_q;
    flen_d  = flen_q;
    fchan_d = fchan_q;
    pchan_d = pchan_q;
    sec_d   = sec_q;
    oui_d   = oui_q;
    pend_d  = pend_q;
    found_d = found_q;
    done    = 1'b0;
    dlen    = len_q;
    off_nx  = off_q + 8'd1;

    if (byte_vld_i && (pos_q < PW'(MAX_FRAME_BYTES))) begin
      pos_d = pos_q + PW'(1);
      if (pos_q == '0) begin
        fc_d = byte_i;
      end
      if ((pos_q >= PW'(16)) && (pos_q <= PW'(21))) begin
        bssid_d = {bssid_q[39:0], byte_i};
      end
      if (pos_q >= PW'(BodyStart)) begin
        case (phase_q)
          PH_ID: begin
            id_d    = byte_i;
            phase_d = PH_LEN;
          end
          PH_LEN: begin
            len_d = byte_i;
            off_d = 8'd0;
            oui_d = 1'b0;
            dlen  = byte_i;
            if (byte_i == 8'd0) begin
              done = 1'b1;
            end else begin
              phase_d = PH_BODY;
            end
          end
          PH_BODY: begin
            if ((id_q == EID_SSID) && (off_q < 8'(SsidSlot))) begin
              pend_d[off_q[4:0]] = byte_i;
            end
            if ((id_q == EID_CHANNEL) && (off_q == 8'd0)) begin
              pchan_d = byte_i;
            end
            if (id_q == EID_VENDOR) begin
              if (off_q == 8'd0) begin
                oui_d = (byte_i == OUI_0);
              end else if (off_q == 8'd1) begin
                oui_d = oui_q && (byte_i == OUI_1);
              end else if (off_q == 8'd2) begin
                oui_d = oui_q && (byte_i == OUI_2);
              end else if (off_q == 8'd3) begin
                oui_d = oui_q && (byte_i == OUI_TYPE);
              end
            end
            off_d = off_nx;
            done  = (off_nx == len_q);
          end
          default: phase_d = PH_ID;
        endcase
      end
    end

    if (done) begin
      phase_d = PH_ID;
      if ((id_d == EID_SSID) && (dlen <= 8'(SsidSlot))) begin
        found_d = pend_d;
        flen_d  = dlen[5:0];
      end else if ((id_d == EID_CHANNEL) && (dlen == 8'd1)) begin
        fchan_d = pchan_d;
      end else if (id_d == EID_RSN) begin
        sec_d = SEC_WPA2;
      end else if ((id_d == EID_VENDOR) && (dlen >= 8'd4) && oui_d) begin
        sec_d = SEC_WPA;
      end
    end

    if (restart_i) begin
      pos_d   = '0;
      fc_d    = 8'd0;
      bssid_d = 48'd0;
      phase_d = PH_ID;
      id_d    = 8'd0;
      len_d   = 8'd0;
      off_d   = 8'd0;
      flen_d  = 6'd0;
      fchan_d = 8'd0;
      pchan_d = 8'd0;
      sec_d   = SEC_OPEN;
      oui_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      fc_q    <= 8'd0;
      bssid_q <= 48'd0;
      phase_q <= PH_ID;
      id_q    <= 8'd0;
      len_q   <= 8'd0;
      off_q   <= 8'd0;
      flen_q  <= 6'd0;
      fchan_q <= 8'd0;
      pchan_q <= 8'd0;
      sec_q   <= SEC_OPEN;
      oui_q   <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      fc_q    <= fc_d;
      bssid_q <= bssid_d;
      phase_q <= phase_d;
      id_q    <= id_d;
      len_q   <= len_d;
      off_q   <= off_d;
      flen_q  <= flen_d;
      fchan_q <= fchan_d;
      pchan_q <= pchan_d;
      sec_q   <= sec_d;
      oui_q   <= oui_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q  <= pend_d;
    found_q <= found_d;
  end

  assign frame_o.pos_ok   = (pos_q >= PW'(BodyStart));
  assign frame_o.fc       = fc_q;
  assign frame_o.bssid    = bssid_q;
  assign frame_o.name_len = flen_q;
  assign frame_o.channel  = fchan_q;
  assign frame_o.security = sec_q;
  assign ssid_byte_o      = found_q[rd_idx_i];

endmodule

// ----- rtl/beacon_scan_table.sv -----
// Channel  | Dir | Transfer carries
// s_axis   | in  | tdata: opcode, data_byte, entry_select, ssid_offset; tlast: last_byte
// m_axis   | out | tdata: status, index, count, bssid, channel, security, len, ssid byte
// cfg      | in  | cfg_we_i / cfg_wdata_i: scanning_enable, written at once
//
// Frame bytes but the last, clears and unused opcodes keep the block idle.
// Last byte of a frame: the result is loaded from the END state, plus the
// SSID copy into the SSID RAM on an insert (one byte per cycle, up to 32 bytes).
// Table read: the RD state loads the result from the registered SSID RAM read.
// A result waits in the output register; a further result-making step holds
// in its state until the output is free. Reset clears the FSM, count, scan enable
// and output valid; no table clearing pass (entries past the count are never read).
module beacon_scan_table #(
  parameter int unsigned MAX_NETWORKS    = bsc_pkg::MaxNetworksDef,
  parameter int unsigned MAX_FRAME_BYTES = bsc_pkg::MaxFrameBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] opcode, [9:2] data_byte, [13:10] entry_select, [18:14] ssid_offset
  input  logic [23:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] status, [6:3] entry_index, [11:7] entry_count, [59:12] bssid_out,
  // [67:60] channel_out, [69:68] security_out, [75:70] ssid_length_out,
  // [83:76] ssid_byte_out
  output logic [87:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i
);
  import bsc_pkg::*;

  localparam int unsigned IW    = (MAX_NETWORKS > 1) ? $clog2(MAX_NETWORKS) : 1;
  localparam int unsigned CW    = $clog2(MAX_NETWORKS + 1);
  localparam int unsigned DEPTH = (2 ** IW) * SsidSlot;
  localparam int unsigned AW    = IW + 5;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_END  = 4'b0010,
    ST_RD   = 4'b0100,
    ST_COPY = 4'b1000
  } state_e;

  state_e        state_q, state_d;
  logic          scan_en_q;
  logic [CW-1:0] count_q, count_d;
  logic [3:0]    sel_q;
  logic [4:0]    off_q;
  logic [IW-1:0] ins_idx_q, ins_idx_d;
  logic [4:0]    cnt_q, cnt_d;
  logic [5:0]    cplen_q, cplen_d;
  logic          m_valid_q;
  logic [87:0]   m_data_q;

  // input fields
  op_e        in_op;
  logic [7:0] in_byte;
  logic [3:0] in_sel;
  logic [4:0] in_off;
  logic       accept;

  assign in_op   = op_e'(s_axis_tdata[1:0]);
  assign in_byte = s_axis_tdata[9:2];
  assign in_sel  = s_axis_tdata[13:10];
  assign in_off  = s_axis_tdata[18:14];
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept  = s_axis_tvalid && s_axis_tready;

  // parser
  bsc_frame_t frame;
  logic [7:0] found_byte;
  logic       restart;

  bsc_parser #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_vld_i  (accept && (in_op == OP_BYTE)),
    .byte_i      (in_byte),
    .restart_i   (restart),
    .rd_idx_i    (cnt_q),
    .frame_o     (frame),
    .ssid_byte_o (found_byte)
  );

  // table cells: the search and the selected entry ripple down the row
  bsc_cell_ctrl_t cell_ctrl [MAX_NETWORKS];
  logic           hit_c     [MAX_NETWORKS+1];
  bsc_entry_t     entry_c   [MAX_NETWORKS+1];
  logic [IW-1:0]  idx_c     [MAX_NETWORKS+1];
  logic [MAX_NETWORKS-1:0] first_hit;
  bsc_entry_t     wr_entry;
  logic           do_insert, do_update;
  logic [5:0]     ins_len;

  assign hit_c[0]   = 1'b0;
  assign entry_c[0] = '0;
  assign idx_c[0]   = '0;

  for (genvar i = 0; i < MAX_NETWORKS; i++) begin : g_cell
    assign cell_ctrl[i].valid       = (32'(count_q) > i);
    assign cell_ctrl[i].write_entry = do_insert && (32'(count_q) == i);
    assign cell_ctrl[i].write_chan  = do_update && first_hit[i];
    assign cell_ctrl[i].pick        = (state_q == ST_RD) ? (32'(sel_q) == i) : first_hit[i];

    bsc_cell #(.IDX_W(IW), .IDX(i)) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl[i]),
      .wr_i    (wr_entry),
      .key_i   (frame.bssid),
      .hit_i   (hit_c[i]),
      .entry_i (entry_c[i]),
      .idx_i   (idx_c[i]),
      .hit_o   (hit_c[i+1]),
      .first_o (first_hit[i]),
      .entry_o (entry_c[i+1]),
      .idx_o   (idx_c[i+1])
    );
  end

  // stored SSID length is capped by the field size
  always_comb begin
    ins_len = frame.name_len;
    if (32'(ins_len) > SsidFieldBytes - 1) begin
      ins_len = 6'(SsidFieldBytes - 1);
    end
  end

  assign wr_entry = '{bssid: frame.bssid, channel: frame.channel,
                      security: frame.security, name_len: ins_len};

  // SSID RAM: slot per entry, copied byte by byte after an insert
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  assign ram_re    = accept && (in_op == OP_READ);
  assign ram_raddr = {IW'(in_sel), in_off};

  bsc_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ssid_ram (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_COPY),
    .waddr_i ({ins_idx_q, cnt_q}),
    .wdata_i (found_byte),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // control
  logic        out_free;
  logic        frame_ok;
  logic        res_load;
  status_e     r_status;
  logic [3:0]  r_idx;
  bsc_entry_t  r_entry;
  logic [7:0]  r_byte;

  assign out_free = !m_valid_q || m_axis_tready;
  assign frame_ok = frame.pos_ok && (frame.fc[3:2] == 2'd0) &&
                    ((frame.fc[7:4] == SUB_BEACON) || (frame.fc[7:4] == SUB_PRESP)) &&
                    scan_en_q && (frame.name_len != 6'd0);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    ins_idx_d = ins_idx_q;
    cnt_d     = cnt_q;
    cplen_d   = cplen_q;
    restart   = 1'b0;
    do_insert = 1'b0;
    do_update = 1'b0;
    res_load  = 1'b0;
    r_status  = STS_IGNORED;
    r_idx     = 4'd0;
    r_entry   = '0;
    r_byte    = 8'd0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_op)
            OP_BYTE:  if (s_axis_tlast) state_d = ST_END;
            OP_CLEAR: count_d = '0;
            OP_READ:  state_d = ST_RD;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_END: begin
        if (out_free) begin
          res_load = 1'b1;
          restart  = 1'b1;
          state_d  = ST_IDLE;
          if (frame_ok) begin
            if (hit_c[MAX_NETWORKS]) begin
              do_update = 1'b1;
              r_status  = STS_UPDATED;
              r_idx     = 4'(idx_c[MAX_NETWORKS]);
              r_entry   = entry_c[MAX_NETWORKS];
              r_entry.channel = frame.channel;
            end else if (32'(count_q) >= MAX_NETWORKS) begin
              r_status = STS_FULL;
            end else begin
              do_insert = 1'b1;
              count_d   = count_q + CW'(1);
              ins_idx_d = IW'(count_q);
              cnt_d     = 5'd0;
              cplen_d   = ins_len;
              r_status  = STS_INSERTED;
              r_idx     = 4'(count_q);
              r_entry   = wr_entry;
              state_d   = ST_COPY;
            end
          end
        end
      end
      ST_RD: begin
        if (out_free) begin
          res_load = 1'b1;
          state_d  = ST_IDLE;
          r_idx    = sel_q;
          if (32'(sel_q) < 32'(count_q)) begin
            r_status = STS_READ;
            r_entry  = entry_c[MAX_NETWORKS];
            if (6'(off_q) < r_entry.name_len) begin
              r_byte = ram_rdata;
            end
          end else begin
            r_status = STS_EMPTY;
          end
        end
      end
      ST_COPY: begin
        cnt_d = cnt_q + 5'd1;
        if ({1'b0, cnt_q} == cplen_q - 6'd1) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      scan_en_q <= 1'b0;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (cfg_we_i) begin
        scan_en_q <= cfg_wdata_i;
      end
      if (res_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ins_idx_q <= ins_idx_d;
    cnt_q     <= cnt_d;
    cplen_q   <= cplen_d;
    if (accept) begin
      sel_q <= in_sel;
      off_q <= in_off;
    end
    if (res_load) begin
      m_data_q <= {4'd0, r_byte, r_entry.name_len, r_entry.security, r_entry.channel,
                   r_entry.bssid, 5'(count_d), r_idx, r_status};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // table never overfills
  a_count_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= MAX_NETWORKS)
    else $error("entry count beyond table size");

  // at most one cell claims the search
  a_one_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(first_hit))
    else $error("several first hits");

  // SSID copy only follows an insert, so the table holds at least one entry
  a_copy_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COPY) |-> (count_q != '0))
    else $error("copy without entry");

  // a result is only loaded into a free output register
  a_no_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_axis_tready) |=> $stable(m_data_q))
    else $error("pending result overwritten");

endmodule
